>>> design/rrfl_pkg.sv
// shared types and codes for the region free list
package rrfl_pkg;
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_FIXED = 2'd1;
   localparam logic [1:0] OP_BACK  = 2'd2;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [63:0] rs;
      logic [63:0] re;
   } region_rec_type;
endpackage

>>> design/rrfl_table.sv
// region table memory with registered read
module rrfl_table import rrfl_pkg::*; #(
   parameter int IDX_W = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  region_rec_type   wr_data,
   input  logic [IDX_W-1:0] rd_idx,
   output region_rec_type   rd_data
);
   region_rec_type mem [0:(1<<IDX_W)-1];
   region_rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> design/ram_region_free_list_core.sv
// Region free-list allocator. One transaction at a time: req_ready is high only when idle and
// the previous response has been taken. The sequencer walks the region memory through one
// registered read port: an add writes its entry in S_BALN and then responds from S_RSP; a back
// reservation reads and checks each scanned entry (S_BRD, S_BCHK) and aligns a fitting one
// (S_BALN), a carve runs a setup step (S_CSET) and then reads and checks each entry (S_CRD,
// S_CCHK), and a split or removal moves each shifted entry with a read and a write (S_SUP/S_SUPW
// or S_SDN/S_SDNW), a split adding a tail write (S_FIN). No clearing pass is needed after reset.
module ram_region_free_list_core import rrfl_pkg::*; #(
   parameter int MAX_REGIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [63:0] req_addr,
   input  logic [63:0] req_length,
   input  logic [5:0]  req_align_shift,
   input  logic [63:0] req_top_limit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_start_addr
);
   localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W = $clog2(MAX_REGIONS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGIONS);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_BRD   = 4'd1;  // back scan read issued
   localparam logic [3:0] S_BCHK  = 4'd2;  // back scan check
   localparam logic [3:0] S_BALN  = 4'd3;  // apply alignment, or append an add
   localparam logic [3:0] S_CSET  = 4'd4;  // carve setup
   localparam logic [3:0] S_CRD   = 4'd5;
   localparam logic [3:0] S_CCHK  = 4'd6;
   localparam logic [3:0] S_SUP   = 4'd7;  // shift up read
   localparam logic [3:0] S_SUPW  = 4'd8;
   localparam logic [3:0] S_SDN   = 4'd9;  // shift down read
   localparam logic [3:0] S_SDNW  = 4'd10;
   localparam logic [3:0] S_FIN   = 4'd11; // split tail write
   localparam logic [3:0] S_RSP   = 4'd12;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] hit_ff, hit_in;
   logic [1:0]       op_ff, op_in;
   logic [63:0]      addr_ff, addr_in;
   logic [63:0]      len_ff, len_in;
   logic [5:0]       shift_ff, shift_in;
   logic [63:0]      limit_ff, limit_in;
   logic [63:0]      lo_ff, lo_in;
   logic [63:0]      hi_ff, hi_in;
   logic [63:0]      top_ff, top_in;
   logic [63:0]      rs_ff, rs_in;
   logic [63:0]      re_ff, re_in;
   logic [1:0]       status_ff, status_in;
   logic [63:0]      chosen_ff, chosen_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_idx, rd_idx;
   region_rec_type   wr_data, rd_data;

   rrfl_table #(.IDX_W(IDX_W)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data),
      .rd_idx(rd_idx), .rd_data(rd_data)
   );

   logic [63:0] lm1, mask, alnd;
   logic [64:0] add_sum;
   assign lm1     = len_ff - 64'd1;
   assign add_sum = {1'b0, addr_ff} + {1'b0, lm1};
   assign mask    = ~((64'd1 << shift_ff) - 64'd1);
   assign alnd    = top_ff & mask;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      len_in       = len_ff;
      shift_in     = shift_ff;
      limit_in     = limit_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      top_in       = top_ff;
      rs_in        = rs_ff;
      re_in        = re_ff;
      status_in    = status_ff;
      chosen_in    = chosen_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_idx       = idx_ff[IDX_W-1:0];
      wr_data      = '{rs: rs_ff, re: re_ff};
      rd_idx       = idx_ff[IDX_W-1:0];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid && !rsp_valid_ff) begin
               op_in     = req_opcode;
               addr_in   = req_addr;
               len_in    = req_length;
               shift_in  = req_align_shift;
               limit_in  = req_top_limit;
               chosen_in = req_addr;
               status_in = ST_NOFIT;
               case (req_opcode)
                  OP_ADD: begin
                     state_in = S_RSP;
                     if (req_length == 64'd0) begin
                        status_in = ST_DONE;
                     end else if (count_ff >= MAX_CNT) begin
                        status_in = ST_FULL;
                     end else begin
                        state_in = S_BALN;
                     end
                  end
                  OP_FIXED: begin
                     lo_in    = req_addr;
                     state_in = (req_length == 64'd0) ? S_RSP : S_CSET;
                  end
                  OP_BACK: begin
                     idx_in   = count_ff - CNT_W'(1);
                     state_in = (req_length == 64'd0 || count_ff == '0) ? S_RSP : S_BRD;
                  end
                  default: state_in = S_RSP;
               endcase
            end
         end
         S_BRD: state_in = S_BCHK;
         S_BCHK: begin
            top_in = rd_data.re;
            rs_in  = rd_data.rs;
            if ((rd_data.re - rd_data.rs) < lm1 || rd_data.rs >= limit_ff ||
                (rd_data.re >= limit_ff && len_ff >= limit_ff - rd_data.rs)) begin
               if (idx_ff == '0) begin
                  state_in = S_RSP;
               end else begin
                  idx_in   = idx_ff - CNT_W'(1);
                  state_in = S_BRD;
               end
            end else begin
               top_in   = ((rd_data.re >= limit_ff) ? limit_ff - 64'd1 : rd_data.re) - lm1;
               state_in = S_BALN;
            end
         end
         S_BALN: begin
            if (op_ff == OP_ADD) begin
               // append, end saturates at all ones
               wr_en    = 1'b1;
               wr_idx   = count_ff[IDX_W-1:0];
               wr_data  = '{rs: addr_ff, re: add_sum[64] ? '1 : add_sum[63:0]};
               count_in = count_ff + CNT_W'(1);
               status_in = ST_DONE;
               state_in = S_RSP;
            end else if (alnd < rs_ff) begin
               if (idx_ff == '0) begin
                  state_in = S_RSP;
               end else begin
                  idx_in   = idx_ff - CNT_W'(1);
                  state_in = S_BRD;
               end
            end else begin
               chosen_in = alnd;
               lo_in     = alnd;
               state_in  = S_CSET;
            end
         end
         S_CSET: begin
            // range overflow never fits
            if (({1'b0, lo_ff} + {1'b0, lm1}) > 65'h0_FFFF_FFFF_FFFF_FFFF ||
                count_ff == '0) begin
               status_in = ST_NOFIT;
               state_in  = S_RSP;
            end else begin
               hi_in    = lo_ff + lm1;
               idx_in   = '0;
               state_in = S_CRD;
            end
         end
         S_CRD: state_in = S_CCHK;
         S_CCHK: begin
            rs_in = rd_data.rs;
            re_in = rd_data.re;
            if (rd_data.rs <= lo_ff && hi_ff <= rd_data.re) begin
               hit_in    = idx_ff;
               status_in = ST_DONE;
               state_in  = S_RSP;
               wr_en     = 1'b1;
               if (lo_ff == rd_data.rs) begin
                  if (hi_ff == rd_data.re) begin
                     idx_in   = idx_ff + CNT_W'(1);
                     state_in = (idx_ff + CNT_W'(1) < count_ff) ? S_SDN : S_RSP;
                     wr_en    = 1'b0;
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     wr_data = '{rs: hi_ff + 64'd1, re: rd_data.re};
                  end
               end else if (hi_ff == rd_data.re) begin
                  wr_data = '{rs: rd_data.rs, re: lo_ff - 64'd1};
               end else if (count_ff >= MAX_CNT) begin
                  wr_en     = 1'b0;
                  status_in = ST_FULL;
               end else begin
                  // head of the split stays at the hit, the tail goes in after the shift
                  wr_data = '{rs: rd_data.rs, re: lo_ff - 64'd1};
                  idx_in  = count_ff - CNT_W'(1);
                  state_in = (count_ff - CNT_W'(1) > idx_ff) ? S_SUP : S_FIN;
               end
            end else if (idx_ff + CNT_W'(1) >= count_ff) begin
               state_in = S_RSP;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_CRD;
            end
         end
         S_SUP: state_in = S_SUPW;
         S_SUPW: begin
            // move entry idx to idx+1, walking down toward the hit
            wr_en   = 1'b1;
            wr_idx  = IDX_W'(idx_ff + CNT_W'(1));
            wr_data = rd_data;
            idx_in  = idx_ff - CNT_W'(1);
            state_in = (idx_ff - CNT_W'(1) > hit_ff) ? S_SUP : S_FIN;
         end
         S_FIN: begin
            wr_en   = 1'b1;
            wr_idx  = IDX_W'(hit_ff + CNT_W'(1));
            wr_data = '{rs: hi_ff + 64'd1, re: re_ff};
            idx_in  = hit_ff;
            state_in = S_RSP;
            count_in = count_ff + CNT_W'(1);
         end
         S_SDN: state_in = S_SDNW;
         S_SDNW: begin
            // move entry idx to idx-1
            wr_en   = 1'b1;
            wr_idx  = IDX_W'(idx_ff - CNT_W'(1));
            wr_data = rd_data;
            idx_in  = idx_ff + CNT_W'(1);
            state_in = (idx_ff < count_ff) ? S_SDN : S_RSP;
         end
         S_RSP: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff    <= idx_in;
      hit_ff    <= hit_in;
      op_ff     <= op_in;
      addr_ff   <= addr_in;
      len_ff    <= len_in;
      shift_ff  <= shift_in;
      limit_ff  <= limit_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      top_ff    <= top_in;
      rs_ff     <= rs_in;
      re_ff     <= re_in;
      status_ff <= status_in;
      chosen_ff <= chosen_in;
   end

   assign req_ready      = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_start_addr = chosen_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT) else $error("region count past capacity");
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("ready while busy");
   a_rsp_after_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RSP) |=> rsp_valid) else $error("response lost");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 2'd3)) else $error("bad status");
`endif
endmodule

>>> test/ram_region_free_list_core_tb.sv
// testbench for the region free list: queued random and directed requests, predicted responses
module ram_region_free_list_core_tb;
   import rrfl_pkg::*;

   localparam int NUM_REGIONS = 16;

   typedef struct {
      logic [1:0]  opcode;
      logic [63:0] addr;
      logic [63:0] length;
      logic [5:0]  align_shift;
      logic [63:0] top_limit;
   } request_type;

   typedef struct {
      logic [1:0]  status;
      logic [63:0] start_addr;
   } response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = OP_ADD;
   logic [63:0] req_addr = '0;
   logic [63:0] req_length = '0;
   logic [5:0]  req_align_shift = '0;
   logic [63:0] req_top_limit = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [63:0] rsp_start_addr;

   ram_region_free_list_core #(.MAX_REGIONS(NUM_REGIONS)) i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [63:0] free_start [NUM_REGIONS];
   logic [63:0] free_end [NUM_REGIONS];
   int unsigned free_count = 0;

   request_type  pending_reqs [$];
   response_type expected_rsps [$];
   int unsigned  send_idle_pct = 20;
   int unsigned  recv_idle_pct = 70;
   bit           hold_request = 1'b0;
   bit           holding = 1'b0;
   bit           in_accepted = 1'b0;
   int unsigned  error_count = 0;

   function automatic void drop_region(input int unsigned idx);
      for (int unsigned k = idx; k + 1 < free_count; k++) begin
         free_start[k] = free_start[k + 1];
         free_end[k] = free_end[k + 1];
      end
      free_count--;
   endfunction

   function automatic logic [1:0] carve_range(input logic [63:0] lo, input logic [63:0] len);
      logic [63:0] hi;
      logic [63:0] rs;
      logic [63:0] re;
      if (len == 0 || lo > 64'hFFFF_FFFF_FFFF_FFFF - (len - 1)) return ST_NOFIT;
      hi = lo + (len - 1);
      for (int unsigned i = 0; i < free_count; i++) begin
         rs = free_start[i];
         re = free_end[i];
         if (!(rs <= lo && hi <= re)) continue;
         if (lo == rs) begin
            if (hi == re) drop_region(i);
            else free_start[i] = hi + 1;
         end else if (hi == re) begin
            free_end[i] = lo - 1;
         end else begin
            if (free_count >= NUM_REGIONS) return ST_FULL;
            for (int unsigned k = free_count; k > i + 1; k--) begin
               free_start[k] = free_start[k - 1];
               free_end[k] = free_end[k - 1];
            end
            free_end[i] = lo - 1;
            free_start[i + 1] = hi + 1;
            free_end[i + 1] = re;
            free_count++;
         end
         return ST_DONE;
      end
      return ST_NOFIT;
   endfunction

   function automatic response_type allocate(input request_type r);
      response_type res;
      logic [63:0] rs;
      logic [63:0] re;
      logic [63:0] top;
      logic [63:0] s;
      res.status = ST_NOFIT;
      res.start_addr = r.addr;
      if (r.opcode == OP_ADD) begin
         if (r.length == 0) res.status = ST_DONE;
         else if (free_count >= NUM_REGIONS) res.status = ST_FULL;
         else begin
            free_start[free_count] = r.addr;
            free_end[free_count] = (r.addr > 64'hFFFF_FFFF_FFFF_FFFF - (r.length - 1)) ?
               64'hFFFF_FFFF_FFFF_FFFF : r.addr + (r.length - 1);
            free_count++;
            res.status = ST_DONE;
         end
      end else if (r.opcode == OP_FIXED) begin
         res.status = carve_range(r.addr, r.length);
      end else if (r.opcode == OP_BACK && r.length != 0) begin
         for (int i = int'(free_count) - 1; i >= 0; i--) begin
            rs = free_start[i];
            re = free_end[i];
            top = re;
            if (re - rs < r.length - 1) continue;
            if (rs >= r.top_limit) continue;
            if (re >= r.top_limit) begin
               if (r.length >= r.top_limit - rs) continue;
               top = r.top_limit - 1;
            end
            s = (top - (r.length - 1)) & ~((64'd1 << r.align_shift) - 1);
            if (s < rs) continue;
            res.start_addr = s;
            res.status = carve_range(s, r.length);
            break;
         end
      end
      return res;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic push_req(input logic [1:0] op, input logic [63:0] a, input logic [63:0] len,
                           input logic [5:0] sh, input logic [63:0] lim);
      request_type r;
      r.opcode = op;
      r.addr = a;
      r.length = len;
      r.align_shift = sh;
      r.top_limit = lim;
      pending_reqs = {pending_reqs, r};
   endtask

   // mostly structured requests that hit the table, some wide-open noise
   task automatic push_random_req();
      logic [63:0] base;
      logic [63:0] len;
      int unsigned pick;
      base = 64'h1000 * $urandom_range(0, 64);
      len = $urandom_range(1, 4) == 1 ? rand64() : 64'd1 + $urandom_range(0, 16'h3000);
      pick = $urandom_range(0, 99);
      if (pick < 30)
         push_req(OP_ADD, base, len, 6'($urandom_range(0, 63)), rand64());
      else if (pick < 60)
         push_req(OP_FIXED, base + $urandom_range(0, 16'h2000), 64'd1 + $urandom_range(0, 16'h800),
                  6'($urandom_range(0, 63)), rand64());
      else if (pick < 88)
         push_req(OP_BACK, rand64(), 64'd1 + $urandom_range(0, 16'h1000),
                  6'($urandom_range(0, 14)),
                  $urandom_range(0, 3) == 0 ? rand64() : base + $urandom_range(0, 16'h8000));
      else
         push_req(2'($urandom_range(0, 3)), rand64(),
                  $urandom_range(0, 3) == 0 ? 64'd0 : rand64(),
                  6'($urandom_range(0, 63)), rand64());
   endtask

   // input handshake seen at the rising edge
   always @(posedge clock) begin
      in_accepted <= !reset && req_valid && req_ready;
   end

   // long receiver hold-off, counted here
   initial begin
      wait (hold_request);
      holding = 1'b1;
      repeat (300) @(negedge clock);
      holding = 1'b0;
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (in_accepted) begin
            automatic request_type r = pending_reqs.pop_front();
            expected_rsps = {expected_rsps, allocate(r)};
         end
         if (in_accepted || !req_valid) begin
            if (pending_reqs.size() > 0 && ($urandom_range(0, 99) >= send_idle_pct)) begin
               req_valid <= 1'b1;
               req_opcode <= pending_reqs[0].opcode;
               req_addr <= pending_reqs[0].addr;
               req_length <= pending_reqs[0].length;
               req_align_shift <= pending_reqs[0].align_shift;
               req_top_limit <= pending_reqs[0].top_limit;
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (holding) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response status=%0d start=%h", $time, rsp_status,
                     rsp_start_addr);
            error_count++;
         end else begin
            automatic response_type e = expected_rsps.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               error_count++;
            end
            if (rsp_start_addr !== e.start_addr) begin
               $display("%0t: start_addr expected %h actual %h", $time, e.start_addr,
                        rsp_start_addr);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, every operation, the special cases
      push_req(OP_FIXED, 64'h100, 64'h10, 6'd0, 64'h0);               // empty table
      push_req(OP_BACK, 64'h0, 64'h10, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      push_req(OP_ADD, 64'h1000, 64'h0, 6'd0, 64'h0);                 // zero length add
      push_req(OP_ADD, 64'hFFFF_FFFF_FFFF_F000, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63,
               64'h0);                                                 // saturate
      push_req(OP_ADD, 64'h1000, 64'h1000, 6'd0, 64'h0);
      push_req(OP_ADD, 64'h0, 64'h100, 6'd0, 64'h0);
      push_req(2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63,
               64'hFFFF_FFFF_FFFF_FFFF);                              // unknown opcode
      push_req(OP_FIXED, 64'h1000, 64'h0, 6'd0, 64'h0);               // zero length fixed
      push_req(OP_BACK, 64'h0, 64'h0, 6'd0, 64'h5000);                // zero length back
      push_req(OP_FIXED, 64'hFFFF_FFFF_FFFF_FFF0, 64'h100, 6'd0, 64'h0); // past the top
      push_req(OP_FIXED, 64'h1400, 64'h100, 6'd0, 64'h0);             // split
      push_req(OP_FIXED, 64'h1000, 64'h100, 6'd0, 64'h0);             // trim front
      push_req(OP_FIXED, 64'h1F00, 64'h100, 6'd0, 64'h0);             // trim back
      push_req(OP_FIXED, 64'h0, 64'h100, 6'd0, 64'h0);                // consume whole
      push_req(OP_BACK, 64'h0, 64'h100, 6'd8, 64'h1800);              // clip at limit
      push_req(OP_BACK, 64'h0, 64'h10, 6'd63, 64'h0);                 // limit zero
      push_req(OP_BACK, 64'h0, 64'h10, 6'd4, 64'hFFFF_FFFF_FFFF_FFFF);
      push_req(OP_ADD, 64'h1100, 64'h400, 6'd0, 64'h0);               // overlapping region
      push_req(OP_BACK, 64'h0, 64'h20, 6'd2, 64'h1300);
      for (int i = 0; i < 16; i++) push_req(OP_ADD, 64'h10000 * (i + 2), 64'h8000, 6'd0, 64'h0);
      push_req(OP_FIXED, 64'h20100, 64'h10, 6'd0, 64'h0);             // split in full table
      push_req(OP_BACK, 64'h0, 64'h10, 6'd0, 64'h20200);              // full from back
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      // long receiver hold-off while requests keep coming
      hold_request = 1'b1;
      for (int i = 0; i < 610; i++) begin
         if (i == 200) begin
            send_idle_pct = 70;
            recv_idle_pct = 20;
         end else if (i == 400) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // occasionally drain the table back out with removals
         push_random_req();
         while (pending_reqs.size() > 8) @(posedge clock);
      end
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_valid) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule

>>> sim.f
design/rrfl_pkg.sv
design/rrfl_table.sv
design/ram_region_free_list_core.sv
test/ram_region_free_list_core_tb.sv
